// ===== design/integer_stack_machine_core_top_defines.svh =====
// ----------------------------------------------------------------------------
// Integer stack machine core assertion macros
// Shared property wrappers for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_STACK_MACHINE_CORE_TOP_DEFINES_SVH
`define INTEGER_STACK_MACHINE_CORE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ISMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ismc_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer stack machine core package
// Sizes, opcodes, error codes and helpers shared by the core files.
// ----------------------------------------------------------------------------
package ismc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SPW = AW + 1;
  localparam int XW = 34;

  localparam logic [6:0] OP_HALT    = 7'd0;
  localparam logic [6:0] OP_PUSH    = 7'd1;
  localparam logic [6:0] OP_POP     = 7'd2;
  localparam logic [6:0] OP_STORE   = 7'd3;
  localparam logic [6:0] OP_LOAD    = 7'd4;
  localparam logic [6:0] OP_GSTORE  = 7'd5;
  localparam logic [6:0] OP_GLOAD   = 7'd6;
  localparam logic [6:0] OP_LDARG0  = 7'd7;
  localparam logic [6:0] OP_SETARG0 = 7'd8;
  localparam logic [6:0] OP_ADD     = 7'd9;
  localparam logic [6:0] OP_SUB     = 7'd10;
  localparam logic [6:0] OP_MUL     = 7'd11;
  localparam logic [6:0] OP_DIV     = 7'd12;
  localparam logic [6:0] OP_MOD     = 7'd13;
  localparam logic [6:0] OP_SHL     = 7'd14;
  localparam logic [6:0] OP_SAR     = 7'd15;
  localparam logic [6:0] OP_AND     = 7'd16;
  localparam logic [6:0] OP_OR      = 7'd17;
  localparam logic [6:0] OP_XOR     = 7'd18;
  localparam logic [6:0] OP_BNOT    = 7'd19;
  localparam logic [6:0] OP_NEG     = 7'd20;
  localparam logic [6:0] OP_NOT     = 7'd28;
  localparam logic [6:0] OP_B2I     = 7'd29;
  localparam logic [6:0] OP_INVOKE  = 7'd31;
  localparam logic [6:0] OP_RESERVE = 7'd32;
  localparam logic [6:0] OP_RETURN  = 7'd33;
  localparam logic [6:0] OP_JMP     = 7'd35;
  localparam logic [6:0] OP_JIF     = 7'd36;
  localparam logic [6:0] OP_BEQ     = 7'd41;
  localparam logic [6:0] OP_IEQ     = 7'd42;
  localparam logic [6:0] OP_BNE     = 7'd44;
  localparam logic [6:0] OP_INE     = 7'd45;
  localparam logic [6:0] OP_ILT     = 7'd47;
  localparam logic [6:0] OP_IGT     = 7'd48;
  localparam logic [6:0] OP_ILE     = 7'd49;
  localparam logic [6:0] OP_IGE     = 7'd50;
  localparam logic [6:0] OP_BAND    = 7'd55;
  localparam logic [6:0] OP_BOR     = 7'd56;
  localparam logic [6:0] OP_UPVAL   = 7'd62;
  localparam logic [6:0] OP_UPSTORE = 7'd63;

  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_OVER  = 3'd1;
  localparam logic [2:0] E_UNDER = 3'd2;
  localparam logic [2:0] E_DIV   = 3'd3;
  localparam logic [2:0] E_UNSUP = 3'd4;
  localparam logic [2:0] E_SLOT  = 3'd5;

  localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);

  typedef logic signed [XW-1:0] wide_t;

  function automatic wide_t sext(input logic [31:0] w);
    sext = {{(XW-32){w[31]}}, w};
  endfunction

  function automatic wide_t zext(input logic [SPW-1:0] v);
    zext = {{(XW-SPW){1'b0}}, v};
  endfunction

  function automatic logic slot_ok(input wide_t x);
    slot_ok = (x >= 0) && (x < DEPTH_X);
  endfunction

endpackage

// ===== design/ismc_if.sv =====
// ----------------------------------------------------------------------------
// Integer stack machine core channels
// Instruction, result and configuration handshake bundles.
// ----------------------------------------------------------------------------
interface ismc_cmd_if;
  logic              valid;
  logic              ready;
  logic [6:0]        op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source(output valid, op, operand_a, operand_b, input ready);
  modport sink(input valid, op, operand_a, operand_b, output ready);
endinterface

interface ismc_res_if;
  logic              valid;
  logic              ready;
  logic [15:0]       next_pc;
  logic signed [31:0] top_value;
  logic [8:0]        stack_depth;
  logic              halted;
  logic [2:0]        error_code;
  modport source(output valid, next_pc, top_value, stack_depth, halted, error_code,
                 input ready);
  modport sink(input valid, next_pc, top_value, stack_depth, halted, error_code,
               output ready);
endinterface

interface ismc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== design/ismc_div.sv =====
// ----------------------------------------------------------------------------
// Integer stack machine core divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ismc_div
  import ismc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic        is_mod,
  output logic        done,
  output logic [31:0] result
);

  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg_q;
  logic        neg_r;
  logic        mod_sel;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[31]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= 6'd0;
        rem     <= '0;
        quo     <= dividend[31] ? (32'd0 - dividend) : dividend;
        den     <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg_q   <= dividend[31] ^ divisor[31];
        neg_r   <= dividend[31];
        mod_sel <= is_mod;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = mod_sel ? (neg_r ? (32'd0 - rem[31:0]) : rem[31:0])
                          : (neg_q ? (32'd0 - quo) : quo);

endmodule

// ===== design/integer_stack_machine_core_top.sv =====
// ----------------------------------------------------------------------------
// Integer stack machine core
// Executes one fetched instruction per command beat on a 256-word stack.
// ----------------------------------------------------------------------------
// Usage: cmd carries one instruction (op, operand_a, operand_b) per beat; res
// returns one beat per instruction with next_pc, top_value, stack_depth,
// halted and error_code; cfg writes error_address, and the user is to do so
// while the core is idle; the block itself does not enforce it (always ready).
// Flow: cmd.ready is high only when the core is idle. Unless the core is
// halted, each command is decoded and then runs its memory, ALU, divider or
// frame steps; unless it fails, the top of stack is read before the result
// beat. The scope walk reads one saved link per frame. The single stack
// memory port (one read, one write per cycle) and the one-bit-per-cycle
// divider set how many steps each instruction takes; the next command is
// taken once the result beat has been accepted, so one instruction is in
// flight at a time.
// Stall: the result stays registered and stable until res.ready; the core
// takes no command meanwhile.
// Reset: synchronous; pc, stack and frame pointers, halt flag and
// error_address go to zero, every stack slot reads as zero until written.
// ----------------------------------------------------------------------------
`include "integer_stack_machine_core_top_defines.svh"

module integer_stack_machine_core_top
  import ismc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ismc_cmd_if.sink cmd,
  ismc_res_if.source res,
  ismc_cfg_if.sink cfg
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DEC   = 5'd1;
  localparam logic [4:0] ST_FRM   = 5'd2;
  localparam logic [4:0] ST_LD    = 5'd3;
  localparam logic [4:0] ST_ST    = 5'd4;
  localparam logic [4:0] ST_B2    = 5'd5;
  localparam logic [4:0] ST_B1    = 5'd6;
  localparam logic [4:0] ST_DIVW  = 5'd7;
  localparam logic [4:0] ST_UN    = 5'd8;
  localparam logic [4:0] ST_JIF   = 5'd9;
  localparam logic [4:0] ST_RET1  = 5'd10;
  localparam logic [4:0] ST_RET2  = 5'd11;
  localparam logic [4:0] ST_RET3  = 5'd12;
  localparam logic [4:0] ST_RET4  = 5'd13;
  localparam logic [4:0] ST_WALK  = 5'd14;
  localparam logic [4:0] ST_WALKD = 5'd15;
  localparam logic [4:0] ST_TOP   = 5'd16;
  localparam logic [4:0] ST_TOPW  = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;
  localparam logic [4:0] ST_INV1  = 5'd19;
  localparam logic [4:0] ST_INV2  = 5'd20;

  localparam logic [SPW-1:0] DEPTH_S = SPW'(STACK_DEPTH);

  // state
  logic [4:0]     st, st_next;
  logic [15:0]    pc, pc_next;
  logic [SPW-1:0] sp, sp_next;
  logic [SPW-1:0] fp, fp_next;
  logic           halt_flag, halt_next;
  logic [15:0]    err_addr;
  logic [6:0]     op_q, op_next;
  logic [31:0]    a_q, a_next;
  logic [31:0]    b_q, b_next;
  logic [2:0]     err, err_next;
  logic [31:0]    top, top_next;
  logic [31:0]    r1, r1_next;
  logic [31:0]    r2, r2_next;
  logic [AW-1:0]  idx, idx_next;
  logic [SPW-1:0] cur, cur_next;
  logic [SPW-1:0] cnt, cnt_next;

  // stack memory
  logic [31:0]            mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] vld;
  logic [31:0]            ram_q;
  logic                   ram_vld;
  logic [31:0]            rd;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wr_addr;
  logic [31:0]            wr_data;

  // divider
  logic        div_start;
  logic        div_done;
  logic [31:0] div_result;

  // scratch
  logic           fail;
  logic [2:0]     fcode;
  wide_t          ix;
  wide_t          a_x;
  wide_t          b_x;
  wide_t          fp_x;
  wide_t          sp_x;
  wide_t          rd_x;
  logic [SPW-1:0] sp_m1;
  logic [SPW-1:0] sp_m2;
  logic [31:0]    alu_r;
  logic [31:0]    un_r;
  logic           is_bin;
  logic           is_un;

  function automatic logic [AW-1:0] fp_m1_addr(input logic [SPW-1:0] f);
    logic [SPW-1:0] t;
    t = f - SPW'(1);
    fp_m1_addr = t[AW-1:0];
  endfunction

  assign rd    = ram_vld ? ram_q : 32'd0;
  assign a_x   = sext(a_q);
  assign b_x   = sext(b_q);
  assign fp_x  = zext(fp);
  assign sp_x  = zext(sp);
  assign rd_x  = sext(rd);
  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);

  assign is_bin = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MUL) ||
                  (op_q == OP_DIV) || (op_q == OP_MOD) || (op_q == OP_SHL) ||
                  (op_q == OP_SAR) || (op_q == OP_AND) || (op_q == OP_OR) ||
                  (op_q == OP_XOR) || (op_q == OP_BEQ) || (op_q == OP_IEQ) ||
                  (op_q == OP_BNE) || (op_q == OP_INE) || (op_q == OP_ILT) ||
                  (op_q == OP_IGT) || (op_q == OP_ILE) || (op_q == OP_IGE) ||
                  (op_q == OP_BAND) || (op_q == OP_BOR);
  assign is_un  = (op_q == OP_BNOT) || (op_q == OP_NEG) || (op_q == OP_NOT) ||
                  (op_q == OP_B2I);

  // shared ALU: u1 comes from the memory read port, u2 from r2
  always_comb begin
    case (op_q)
      OP_ADD:  alu_r = rd + r2;
      OP_SUB:  alu_r = rd - r2;
      OP_MUL:  alu_r = rd * r2;
      OP_SHL:  alu_r = rd << r2[4:0];
      OP_SAR:  alu_r = $unsigned($signed(rd) >>> r2[4:0]);
      OP_AND:  alu_r = rd & r2;
      OP_OR:   alu_r = rd | r2;
      OP_XOR:  alu_r = rd ^ r2;
      OP_BEQ:  alu_r = {31'd0, (rd != 32'd0) == (r2 != 32'd0)};
      OP_IEQ:  alu_r = {31'd0, rd == r2};
      OP_BNE:  alu_r = {31'd0, (rd != 32'd0) != (r2 != 32'd0)};
      OP_INE:  alu_r = {31'd0, rd != r2};
      OP_ILT:  alu_r = {31'd0, $signed(rd) < $signed(r2)};
      OP_IGT:  alu_r = {31'd0, $signed(rd) > $signed(r2)};
      OP_ILE:  alu_r = {31'd0, $signed(rd) <= $signed(r2)};
      OP_IGE:  alu_r = {31'd0, $signed(rd) >= $signed(r2)};
      OP_BAND: alu_r = {31'd0, (rd != 32'd0) && (r2 != 32'd0)};
      default: alu_r = {31'd0, (rd != 32'd0) || (r2 != 32'd0)};
    endcase
  end

  always_comb begin
    case (op_q)
      OP_BNOT: un_r = ~rd;
      OP_NEG:  un_r = 32'd0 - rd;
      OP_NOT:  un_r = {31'd0, rd == 32'd0};
      default: un_r = {31'd0, rd != 32'd0};
    endcase
  end

  ismc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd),
    .divisor  (r2),
    .is_mod   (op_q == OP_MOD),
    .done     (div_done),
    .result   (div_result)
  );

  always_comb begin
    st_next   = st;
    pc_next   = pc;
    sp_next   = sp;
    fp_next   = fp;
    halt_next = halt_flag;
    op_next   = op_q;
    a_next    = a_q;
    b_next    = b_q;
    err_next  = err;
    top_next  = top;
    r1_next   = r1;
    r2_next   = r2;
    idx_next  = idx;
    cur_next  = cur;
    cnt_next  = cnt;
    rd_addr   = sp_m1[AW-1:0];
    we        = 1'b0;
    wr_addr   = sp[AW-1:0];
    wr_data   = rd;
    div_start = 1'b0;
    fail      = 1'b0;
    fcode     = E_NONE;
    ix        = '0;

    case (st)
      ST_IDLE: begin
        if (cmd.valid) begin
          op_next  = cmd.op;
          a_next   = cmd.operand_a;
          b_next   = cmd.operand_b;
          err_next = E_NONE;
          if (halt_flag) begin
            st_next = ST_TOP;
          end else begin
            pc_next = pc + 16'd1;
            st_next = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        case (op_q)
          OP_HALT: begin
            halt_next = 1'b1;
            st_next   = ST_TOP;
          end
          OP_PUSH: begin
            if (sp >= DEPTH_S) begin
              fail = 1'b1; fcode = E_OVER;
            end else begin
              we      = 1'b1;
              wr_data = a_q;
              sp_next = sp + SPW'(1);
              st_next = ST_TOP;
            end
          end
          OP_POP, OP_JIF: begin
            if (sp == '0) begin
              fail = 1'b1; fcode = E_UNDER;
            end else begin
              sp_next = sp_m1;
              st_next = (op_q == OP_JIF) ? ST_JIF : ST_TOP;
            end
          end
          OP_STORE, OP_GSTORE: begin
            ix = (op_q == OP_STORE) ? (fp_x + a_x) : a_x;
            if (sp == '0) begin
              fail = 1'b1; fcode = E_UNDER;
            end else if (!slot_ok(ix)) begin
              fail = 1'b1; fcode = E_SLOT;
            end else begin
              idx_next = ix[AW-1:0];
              st_next  = ST_ST;
            end
          end
          OP_LOAD, OP_GLOAD: begin
            ix = (op_q == OP_LOAD) ? (fp_x + a_x) : a_x;
            if (!slot_ok(ix)) begin
              fail = 1'b1; fcode = E_SLOT;
            end else begin
              rd_addr = ix[AW-1:0];
              st_next = ST_LD;
            end
          end
          OP_SETARG0, OP_LDARG0: begin
            ix = fp_x - 3;
            if ((op_q == OP_SETARG0) && (sp == '0)) begin
              fail = 1'b1; fcode = E_UNDER;
            end else if (!slot_ok(ix)) begin
              fail = 1'b1; fcode = E_SLOT;
            end else begin
              rd_addr = ix[AW-1:0];
              st_next = ST_FRM;
            end
          end
          OP_INVOKE: begin
            if (sp_x + 3 > DEPTH_X) begin
              fail = 1'b1; fcode = E_OVER;
            end else begin
              we      = 1'b1;
              wr_data = b_q;
              st_next = ST_INV1;
            end
          end
          OP_RESERVE: begin
            ix = sp_x + a_x;
            if (ix < 0) begin
              fail = 1'b1; fcode = E_UNDER;
            end else if (ix > DEPTH_X) begin
              fail = 1'b1; fcode = E_OVER;
            end else begin
              sp_next = ix[SPW-1:0];
              st_next = ST_TOP;
            end
          end
          OP_RETURN: begin
            if ((sp == '0) || (fp < SPW'(3))) begin
              fail = 1'b1; fcode = E_UNDER;
            end else begin
              st_next = ST_RET1;
            end
          end
          OP_JMP: begin
            pc_next = a_q[15:0];
            st_next = ST_TOP;
          end
          OP_UPVAL, OP_UPSTORE: begin
            if ((op_q == OP_UPSTORE) && (sp == '0)) begin
              fail = 1'b1; fcode = E_UNDER;
            end else if (a_x > DEPTH_X) begin
              fail = 1'b1; fcode = E_SLOT;
            end else begin
              cnt_next = (a_x <= 0) ? '0 : a_q[SPW-1:0];
              cur_next = fp;
              st_next  = ST_WALK;
            end
          end
          default: begin
            if (is_bin) begin
              if (sp < SPW'(2)) begin
                fail = 1'b1; fcode = E_UNDER;
              end else begin
                st_next = ST_B2;
              end
            end else if (is_un) begin
              if (sp == '0) begin
                fail = 1'b1; fcode = E_UNDER;
              end else begin
                st_next = ST_UN;
              end
            end else begin
              fail = 1'b1; fcode = E_UNSUP;
            end
          end
        endcase
      end
      ST_FRM: begin
        ix = fp_x - rd_x - 4;
        if (!slot_ok(ix)) begin
          fail = 1'b1; fcode = E_SLOT;
        end else begin
          idx_next = ix[AW-1:0];
          if (op_q == OP_LDARG0) begin
            rd_addr = ix[AW-1:0];
            st_next = ST_LD;
          end else begin
            st_next = ST_ST;
          end
        end
      end
      ST_LD: begin
        if (sp >= DEPTH_S) begin
          fail = 1'b1; fcode = E_OVER;
        end else begin
          we      = 1'b1;
          sp_next = sp + SPW'(1);
          st_next = ST_TOP;
        end
      end
      ST_ST: begin
        we      = 1'b1;
        wr_addr = idx;
        sp_next = sp_m1;
        st_next = ST_TOP;
      end
      ST_B2: begin
        r2_next = rd;
        rd_addr = sp_m2[AW-1:0];
        st_next = ST_B1;
      end
      ST_B1: begin
        if ((op_q == OP_DIV) || (op_q == OP_MOD)) begin
          if (r2 == 32'd0) begin
            fail = 1'b1; fcode = E_DIV;
          end else begin
            div_start = 1'b1;
            st_next   = ST_DIVW;
          end
        end else begin
          we      = 1'b1;
          wr_addr = sp_m2[AW-1:0];
          wr_data = alu_r;
          sp_next = sp_m1;
          st_next = ST_TOP;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          we      = 1'b1;
          wr_addr = sp_m2[AW-1:0];
          wr_data = div_result;
          sp_next = sp_m1;
          st_next = ST_TOP;
        end
      end
      ST_UN: begin
        we      = 1'b1;
        wr_addr = sp_m1[AW-1:0];
        wr_data = un_r;
        st_next = ST_TOP;
      end
      ST_JIF: begin
        if (rd == 32'd0) begin
          pc_next = a_q[15:0];
        end
        st_next = ST_TOP;
      end
      ST_RET1: begin
        r1_next = rd;
        ix      = fp_x - 2;
        rd_addr = ix[AW-1:0];
        st_next = ST_RET2;
      end
      ST_RET2: begin
        ix = fp_x - 3;
        if ((rd_x < 0) || (rd_x > DEPTH_X)) begin
          fail = 1'b1; fcode = E_SLOT;
        end else begin
          r2_next = rd;
          rd_addr = ix[AW-1:0];
          st_next = ST_RET3;
        end
      end
      ST_RET3: begin
        ix = fp_x - 3 - rd_x;
        if (ix < 0) begin
          fail = 1'b1; fcode = E_UNDER;
        end else if (ix >= DEPTH_X) begin
          fail = 1'b1; fcode = E_OVER;
        end else begin
          idx_next = ix[AW-1:0];
          rd_addr  = fp_m1_addr(fp);
          st_next  = ST_RET4;
        end
      end
      ST_RET4: begin
        pc_next = rd[15:0];
        fp_next = r2[SPW-1:0];
        we      = 1'b1;
        wr_addr = idx;
        wr_data = r1;
        sp_next = {1'b0, idx} + SPW'(1);
        st_next = ST_TOP;
      end
      ST_INV1: begin
        we      = 1'b1;
        wr_addr = AW'(sp + SPW'(1));
        wr_data = {{(32-SPW){1'b0}}, fp};
        st_next = ST_INV2;
      end
      ST_INV2: begin
        we      = 1'b1;
        wr_addr = AW'(sp + SPW'(2));
        wr_data = {16'd0, pc};
        sp_next = sp + SPW'(3);
        fp_next = sp + SPW'(3);
        pc_next = a_q[15:0];
        st_next = ST_TOP;
      end
      ST_WALK: begin
        if (cnt == '0) begin
          ix = zext(cur) + b_x;
          if (!slot_ok(ix)) begin
            fail = 1'b1; fcode = E_SLOT;
          end else begin
            idx_next = ix[AW-1:0];
            if (op_q == OP_UPVAL) begin
              rd_addr = ix[AW-1:0];
              st_next = ST_LD;
            end else begin
              st_next = ST_ST;
            end
          end
        end else begin
          ix = zext(cur) - 2;
          if (!slot_ok(ix)) begin
            fail = 1'b1; fcode = E_SLOT;
          end else begin
            rd_addr = ix[AW-1:0];
            st_next = ST_WALKD;
          end
        end
      end
      ST_WALKD: begin
        if ((rd_x < 0) || (rd_x > DEPTH_X)) begin
          fail = 1'b1; fcode = E_SLOT;
        end else begin
          cur_next = rd[SPW-1:0];
          cnt_next = cnt - SPW'(1);
          st_next  = ST_WALK;
        end
      end
      ST_TOP: begin
        st_next = ST_TOPW;
      end
      ST_TOPW: begin
        top_next = (sp != '0) ? rd : 32'd0;
        st_next  = ST_OUT;
      end
      ST_OUT: begin
        if (res.ready) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    // error: drop the stack, jump to the handler, report with an empty top
    if (fail) begin
      we       = 1'b0;
      div_start = 1'b0;
      err_next = fcode;
      sp_next  = '0;
      pc_next  = err_addr;
      top_next = 32'd0;
      st_next  = ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pc        <= '0;
      sp        <= '0;
      fp        <= '0;
      halt_flag <= 1'b0;
      err_addr  <= '0;
      vld       <= '0;
      err       <= E_NONE;
    end else begin
      st        <= st_next;
      pc        <= pc_next;
      sp        <= sp_next;
      fp        <= fp_next;
      halt_flag <= halt_next;
      err       <= err_next;
      if (cfg.valid) begin
        err_addr <= cfg.data;
      end
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q <= op_next;
    a_q  <= a_next;
    b_q  <= b_next;
    top  <= top_next;
    r1   <= r1_next;
    r2   <= r2_next;
    idx  <= idx_next;
    cur  <= cur_next;
    cnt  <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    ram_q   <= mem[rd_addr];
    ram_vld <= vld[rd_addr];
  end

  assign cmd.ready       = (st == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign res.valid       = (st == ST_OUT);
  assign res.next_pc     = pc;
  assign res.top_value   = top;
  assign res.stack_depth = sp;
  assign res.halted      = halt_flag;
  assign res.error_code  = err;

  `ISMC_ASSERT_NOW(a_err_clears, res.valid && (res.error_code != E_NONE), (res.stack_depth == '0) && (res.top_value == 32'd0), "error result with a non-empty stack")
  `ISMC_ASSERT_NOW(a_no_overlap, cmd.ready, !res.valid, "command taken while a result is pending")
  `ISMC_ASSERT_NEXT(a_halt_sticky, halt_flag, halt_flag, "halt flag dropped without reset")
  `ISMC_ASSERT_NOW(a_div_depth, st == ST_DIVW, sp >= SPW'(2), "divide in flight with fewer than two operands")

endmodule
